### hdl/utd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Shared types, constants and the code unit emission function.
// ----------------------------------------------------------------------------
package utd_pkg;

	localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;
	localparam logic [20:0] SUPP_OFFSET      = 21'h010000;
	localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
	localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;

	// configuration register indexes
	localparam logic [1:0] CFG_IDX_NUL_TERM  = 2'd0;
	localparam logic [1:0] CFG_IDX_WIDE      = 2'd1;
	localparam logic [1:0] CFG_IDX_LOW_FIRST = 2'd2;

	// result queue geometry
	localparam int OBUF_DEPTH = 4;
	localparam int OBUF_AW    = $clog2(OBUF_DEPTH);

	typedef struct packed {
		logic nul_terminated;
		logic wide_units;
		logic low_surrogate_first;
	} cfg_t;

	typedef struct packed {
		logic [20:0] code_unit;
		logic        last_of_run;
		logic        end_of_string;
	} unit_t;

	// up to two units caused by one input byte
	typedef struct packed {
		logic [1:0] count;
		unit_t      u0;
		unit_t      u1;
	} res_t;

	// emit one value, split into a surrogate pair in 16-bit mode when above 0xFFFF
	function automatic res_t emit_value(input logic [20:0] value, input logic eos,
			input cfg_t cfg);
		res_t        r;
		logic [20:0] v;
		logic [15:0] hi;
		logic [15:0] lo;
		r  = '0;
		v  = value - SUPP_OFFSET;
		hi = HIGH_SURR_BASE | {5'd0, v[20:10]};
		lo = LOW_SURR_BASE | {6'd0, v[9:0]};
		if (!cfg.wide_units && (value[20:16] != 5'd0)) begin
			r.count = 2'd2;
			if (cfg.low_surrogate_first) begin
				r.u0 = '{code_unit: {5'd0, lo}, last_of_run: 1'b0, end_of_string: 1'b0};
				r.u1 = '{code_unit: {5'd0, hi}, last_of_run: 1'b1, end_of_string: eos};
			end else begin
				r.u0 = '{code_unit: {5'd0, hi}, last_of_run: 1'b0, end_of_string: 1'b0};
				r.u1 = '{code_unit: {5'd0, lo}, last_of_run: 1'b1, end_of_string: eos};
			end
		end else begin
			r.count = 2'd1;
			r.u0    = '{code_unit: value, last_of_run: 1'b1, end_of_string: eos};
		end
		return r;
	endfunction

endpackage

### hdl/utf8_to_utf16_decoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder, top level
// Byte-wide UTF-8 in, 21-bit code units out, with a plain configuration port.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per cycle and decodes it against the held
// sequence state in a single pass; the units that the byte causes land in a
// four-entry result queue and appear on the output from the next cycle on. The
// output side drains one unit per cycle while out_stall is low, so bytes that
// end a code point above U+FFFF in 16-bit mode (two surrogate halves) slow the
// input down: in_stall rises while fewer than two queue slots are free. Each
// byte causes no unit at all (it only adds to a sequence), one unit, or two.
// Write configuration only while the block is idle; writes to index 3 are
// dropped.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_top import utd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	// input bytes
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_input,
	// output units
	output logic        out_valid,
	input  logic        out_stall,
	output logic [20:0] code_unit,
	output logic        last_of_run,
	output logic        end_of_string
);

	cfg_t  cfg_q;
	res_t  dec_res;
	unit_t head;
	logic  in_acc;
	logic  out_acc;
	logic  busy;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign in_stall = busy;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_NUL_TERM:  cfg_q.nul_terminated      <= cfg_data;
				CFG_IDX_WIDE:      cfg_q.wide_units          <= cfg_data;
				CFG_IDX_LOW_FIRST: cfg_q.low_surrogate_first <= cfg_data;
				default:           cfg_q                     <= cfg_q;
			endcase
		end
	end

	// decode the byte against the sequence state
	utd_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_acc),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.cfg          (cfg_q),
		.res          (dec_res)
	);

	// queue the units and present them one at a time
	utd_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_acc),
		.res        (dec_res),
		.pop        (out_acc),
		.head       (head),
		.head_valid (out_valid),
		.busy       (busy)
	);

	assign code_unit     = head.code_unit;
	assign last_of_run   = head.last_of_run;
	assign end_of_string = head.end_of_string;

endmodule

### hdl/utd_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 sequence decoder
// Holds the sequence state and works out the units that each byte causes.
// ----------------------------------------------------------------------------
module utd_decode import utd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	input  cfg_t       cfg,
	output res_t       res
);

	logic [20:0] acc_q, acc_d;
	logic [2:0]  pend_q, pend_d;
	logic        bad_q, bad_d;

	logic [20:0] acc_fold;
	logic [2:0]  pend_dec;
	logic [2:0]  follow;
	logic [4:0]  init;
	logic        lead_bad;
	logic        fin;

	always_comb begin
		follow   = 3'd0;
		init     = 5'd0;
		lead_bad = 1'b0;
		unique case (in_byte) inside
			[8'h00:8'h7F]: begin
				follow = 3'd0;
			end
			[8'h80:8'hC1]: begin
				follow   = 3'd1;
				lead_bad = 1'b1;
			end
			[8'hC2:8'hDF]: begin
				follow = 3'd1;
				init   = in_byte[4:0];
			end
			[8'hE0:8'hEF]: begin
				follow = 3'd2;
				init   = {1'b0, in_byte[3:0]};
			end
			[8'hF0:8'hF4]: begin
				follow = 3'd3;
				init   = {2'b0, in_byte[2:0]};
			end
			[8'hF5:8'hF7]: begin
				follow   = 3'd3;
				lead_bad = 1'b1;
			end
			[8'hF8:8'hFB]: begin
				follow   = 3'd4;
				lead_bad = 1'b1;
			end
			[8'hFC:8'hFD]: begin
				follow   = 3'd5;
				lead_bad = 1'b1;
			end
			8'hFE: begin
				follow   = 3'd6;
				lead_bad = 1'b1;
			end
			default: begin
				follow   = 3'd7;
				lead_bad = 1'b1;
			end
		endcase
	end

	always_comb begin
		fin      = !cfg.nul_terminated && end_of_input;
		acc_fold = {acc_q[14:0], in_byte[5:0]};
		pend_dec = pend_q - 3'd1;
		acc_d    = acc_q;
		pend_d   = pend_q;
		bad_d    = bad_q;
		res      = '0;
		if (cfg.nul_terminated && (in_byte == 8'd0)) begin
			// terminator: flush a cut-short sequence, then the zero unit
			acc_d  = '0;
			pend_d = '0;
			bad_d  = 1'b0;
			if (pend_q != 3'd0) begin
				res.count = 2'd2;
				res.u0    = '{code_unit: REPLACEMENT_CHAR, last_of_run: 1'b0,
					end_of_string: 1'b0};
				res.u1    = '{code_unit: '0, last_of_run: 1'b1, end_of_string: 1'b1};
			end else begin
				res.count = 2'd1;
				res.u0    = '{code_unit: '0, last_of_run: 1'b1, end_of_string: 1'b1};
			end
		end else if (pend_q != 3'd0) begin
			if (!bad_q) begin
				acc_d = acc_fold;
			end
			pend_d = pend_dec;
			if (pend_dec == 3'd0) begin
				res    = emit_value(bad_q ? REPLACEMENT_CHAR : acc_fold, fin, cfg);
				acc_d  = '0;
				bad_d  = 1'b0;
			end else if (fin) begin
				res.count = 2'd1;
				res.u0    = '{code_unit: REPLACEMENT_CHAR, last_of_run: 1'b1,
					end_of_string: 1'b1};
				acc_d     = '0;
				pend_d    = '0;
				bad_d     = 1'b0;
			end
		end else begin
			if (follow == 3'd0) begin
				res = emit_value({13'd0, in_byte}, fin, cfg);
			end else if (fin) begin
				res.count = 2'd1;
				res.u0    = '{code_unit: REPLACEMENT_CHAR, last_of_run: 1'b1,
					end_of_string: 1'b1};
			end else begin
				acc_d  = lead_bad ? '0 : {16'd0, init};
				pend_d = follow;
				bad_d  = lead_bad;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= '0;
			bad_q  <= 1'b0;
		end else if (accept) begin
			acc_q  <= acc_d;
			pend_q <= pend_d;
			bad_q  <= bad_d;
		end
	end

endmodule

### hdl/utd_out_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two units per cycle and hands out one per pop.
// ----------------------------------------------------------------------------
module utd_out_fifo import utd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  res_t  res,
	input  logic  pop,
	output unit_t head,
	output logic  head_valid,
	output logic  busy
);

	unit_t              mem_q [OBUF_DEPTH];
	logic [OBUF_AW-1:0] wr_q;
	logic [OBUF_AW-1:0] rd_q;
	logic [OBUF_AW:0]   cnt_q;
	logic [OBUF_AW:0]   push_n;
	logic [OBUF_AW:0]   pop_n;

	assign push_n     = push ? (OBUF_AW+1)'(res.count) : '0;
	assign pop_n      = pop ? (OBUF_AW+1)'(1) : '0;
	assign head       = mem_q[rd_q];
	assign head_valid = cnt_q != '0;
	// hold off input unless two slots are free
	assign busy       = cnt_q > (OBUF_AW+1)'(OBUF_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push && (res.count != 2'd0)) begin
			mem_q[wr_q] <= res.u0;
		end
		if (push && (res.count == 2'd2)) begin
			mem_q[wr_q + OBUF_AW'(1)] <= res.u1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push_n[OBUF_AW-1:0];
			rd_q  <= rd_q + pop_n[OBUF_AW-1:0];
			cnt_q <= cnt_q + push_n - pop_n;
		end
	end

endmodule

### hdl/utd_checker.sv
// ----------------------------------------------------------------------------
// Decoder port checker
// Watches the top level ports and flags queue and handshake slips.
// ----------------------------------------------------------------------------
module utd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [20:0] code_unit,
	input logic        last_of_run,
	input logic        end_of_string
);

	// a stalled output item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code_unit)
			&& $stable(last_of_run) && $stable(end_of_string))
		else $error("output item changed while stalled");

	// the second half of a pair is already queued
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |=> out_valid)
		else $error("unit run broken off");

	// input is held off only while the queue holds items
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty result queue");

	// a closing unit is always the last of its run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_string |-> last_of_run)
		else $error("string closed mid-run");

endmodule

bind utf8_to_utf16_decoder_top utd_checker u_checker (.*);
